// File: rtl/ivcdp_pkg.sv
// Shared types and constants for the integer value cache with delta prediction.
package ivcdp_pkg;

    // Fixed widths of the item fields.
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int HIDX_W  = 4;
    localparam int SIZE_W  = 6;
    localparam int POS_W   = 6;
    localparam int CHG_W   = 5;
    localparam int PADDR_W = 3;

    // Reset value of the mask register and the floor of the block size.
    localparam logic [DATA_W-1:0] MASK_RESET     = 32'hFFFF_FFFF;
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_MIN = 6'd2;

    // Register index of the value mask in the configuration space.
    localparam logic CFG_IDX_MASK = 1'b0;

    // Command codes; code 3 is unknown and changes nothing.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_PUSH   = 2'd2
    } cmd_t;

    // Main sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OPEN,
        ST_SHIFT,
        ST_WRITE,
        ST_PREDICT,
        ST_FINISH
    } state_t;

    // Request to the block-size predictor.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] delta;
    } pred_req_t;

    // Response from the block-size predictor.
    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] size;
    } pred_rsp_t;

endpackage

// File: rtl/ivcdp_if.sv
// Valid/ready channel interfaces for command items and result items.
interface ivcdp_in_if;
    logic                          valid;
    logic                          ready;
    logic [ivcdp_pkg::CMD_W-1:0]   command;
    logic [ivcdp_pkg::DATA_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface ivcdp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [ivcdp_pkg::HIDX_W-1:0]  hit_index;
    logic [ivcdp_pkg::DATA_W-1:0]  value_out;
    logic                          same_diff;
    logic [ivcdp_pkg::SIZE_W-1:0]  block_size;

    modport source (output valid, output hit, output hit_index, output value_out,
                    output same_diff, output block_size, input ready);
    modport sink   (input valid, input hit, input hit_index, input value_out,
                    input same_diff, input block_size, output ready);
endinterface

// File: rtl/int_value_cache_delta_predictor.sv
// Top level of the self-organizing integer value cache with delta and block-size prediction.
// One item is handled at a time; the cache lives in a single memory with one read and
// one write per cycle and a registered read, and everything goes through that port pair.
// A lookup scans one entry per cycle (up to the fill count), a hit moves the entry to half
// its index by shifting the entries in between one per cycle, and a miss, insert or push
// opens a slot by shifting the entries above it one per cycle. When the stored delta
// changes, the block-size predictor then walks the mask bits from bit 1 upward, one per
// cycle, for as long as they are set. A finished result waits in an
// output register, and the next item is taken meanwhile. No clearing pass follows reset:
// only filled entries are ever read.
module int_value_cache_delta_predictor #(
    parameter int CACHE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ivcdp_in_if.sink                      in_ch,
    ivcdp_out_if.source                   out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ivcdp_pkg::PADDR_W-1:0] paddr,
    input  logic [ivcdp_pkg::DATA_W-1:0]  pwdata,
    output logic [ivcdp_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import ivcdp_pkg::*;

    localparam int IDX_W  = $clog2(CACHE_DEPTH);
    localparam int FILL_W = $clog2(CACHE_DEPTH + 1);

    // Sequencer and work registers.
    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [DATA_W-1:0] wr_val_reg, wr_val_next;
    logic              pend_reg, pend_next;
    logic [DATA_W-1:0] pdelta_reg, pdelta_next;

    // Architectural state beside the memory.
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [DATA_W-1:0] li_reg, li_next;
    logic [DATA_W-1:0] ld_reg, ld_next;
    logic [DATA_W-1:0] mask_reg, mask_next;

    // Result under construction and the output register.
    logic              res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [DATA_W-1:0] res_vout_reg, res_vout_next;
    logic              res_same_reg, res_same_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg;
    logic [HIDX_W-1:0] out_idx_reg;
    logic [DATA_W-1:0] out_vout_reg;
    logic              out_same_reg;
    logic [SIZE_W-1:0] out_size_reg;

    // Memory port signals.
    logic [DATA_W-1:0] mem [CACHE_DEPTH];
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    // Shared helper signals.
    logic              in_fire;
    logic              load_out;
    logic              match;
    logic              scan_more;
    logic              shift_more;
    logic              full;
    logic [IDX_W-1:0]  open_at;
    logic [IDX_W-1:0]  open_top;
    logic [IDX_W-1:0]  shift_top;
    logic [IDX_W-1:0]  shift_lo;
    logic              shift_go;
    logic [DATA_W-1:0] miss_delta;
    logic [DATA_W-1:0] ins_value;
    logic              cfg_wr;
    pred_req_t         pred_req;
    pred_rsp_t         pred_rsp;

    assign in_fire    = in_ch.valid && in_ch.ready;
    assign load_out   = (state_reg == ST_FINISH) && (!out_valid_reg || out_ch.ready);
    assign match      = (rd_data == val_reg);
    assign scan_more  = (FILL_W'(idx_reg) + FILL_W'(1)) < fill_reg;
    assign shift_more = idx_reg > (lo_reg + IDX_W'(1));
    assign full       = fill_reg >= FILL_W'(CACHE_DEPTH);
    assign open_at    = (fill_reg <= FILL_W'(2)) ? IDX_W'(fill_reg) : IDX_W'(2);
    assign open_top   = full ? IDX_W'(CACHE_DEPTH - 1) : IDX_W'(fill_reg);
    assign miss_delta = (val_reg - li_reg) & mask_reg;
    assign ins_value  = (li_reg + val_reg) & mask_reg;

    // Range of the shift: a hit moves to half its index, other commands open a slot.
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            shift_top = idx_reg;
            shift_lo  = idx_reg >> 1;
        end
        else
        begin
            shift_top = open_top;
            shift_lo  = (cmd_reg == CMD_PUSH) ? '0 : open_at;
        end
    end
    assign shift_go = shift_top > shift_lo;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_ch.command)
                        CMD_LOOKUP: state_next = (fill_reg == '0) ? ST_OPEN : ST_SCAN;
                        CMD_INSERT: state_next = ST_OPEN;
                        CMD_PUSH:   state_next = ST_OPEN;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = shift_go ? ST_SHIFT : ST_WRITE;
                end
                else if (!scan_more)
                begin
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN:    state_next = shift_go ? ST_SHIFT : ST_WRITE;
            ST_SHIFT:   state_next = shift_more ? ST_SHIFT : ST_WRITE;
            ST_WRITE:   state_next = pend_reg ? ST_PREDICT : ST_FINISH;
            ST_PREDICT: state_next = pred_rsp.done ? ST_FINISH : ST_PREDICT;
            ST_FINISH:  state_next = load_out ? ST_IDLE : ST_FINISH;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory accesses, predictor start and handshake outputs.
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = '0;
        we             = 1'b0;
        wr_addr        = '0;
        wr_data        = wr_val_reg;
        pred_req.start = 1'b0;
        pred_req.delta = pdelta_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_en   = in_fire && (in_ch.command == CMD_LOOKUP);
                rd_addr = '0;
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    rd_en   = shift_go;
                    rd_addr = shift_top - IDX_W'(1);
                end
                else
                begin
                    rd_en   = scan_more;
                    rd_addr = idx_reg + IDX_W'(1);
                end
            end
            ST_OPEN:
            begin
                rd_en   = shift_go;
                rd_addr = shift_top - IDX_W'(1);
            end
            ST_SHIFT:
            begin
                we      = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                rd_en   = shift_more;
                rd_addr = idx_reg - IDX_W'(2);
            end
            ST_WRITE:
            begin
                we             = 1'b1;
                wr_addr        = lo_reg;
                pred_req.start = pend_reg;
            end
            ST_PREDICT, ST_FINISH:
            begin
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == ST_IDLE);

    // Work register and cache state updates.
    always_comb
    begin
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        lo_next       = lo_reg;
        wr_val_next   = wr_val_reg;
        pend_next     = pend_reg;
        pdelta_next   = pdelta_reg;
        fill_next     = fill_reg;
        li_next       = li_reg;
        ld_next       = ld_reg;
        res_hit_next  = res_hit_reg;
        res_idx_next  = res_idx_reg;
        res_vout_next = res_vout_reg;
        res_same_next = res_same_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next      = cmd_t'(in_ch.command);
                    val_next      = in_ch.value;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    res_hit_next  = 1'b0;
                    res_idx_next  = '0;
                    res_vout_next = '0;
                    res_same_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    res_hit_next  = 1'b1;
                    res_idx_next  = idx_reg;
                    res_vout_next = val_reg;
                    wr_val_next   = val_reg;
                    idx_next      = shift_top;
                    lo_next       = shift_lo;
                end
                else if (scan_more)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_OPEN:
            begin
                idx_next = shift_top;
                lo_next  = shift_lo;
                if (!full)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                unique case (cmd_reg)
                    CMD_LOOKUP:
                    begin
                        wr_val_next   = val_reg;
                        li_next       = val_reg & mask_reg;
                        res_vout_next = miss_delta;
                        res_same_next = (miss_delta == ld_reg);
                        if (miss_delta != ld_reg)
                        begin
                            ld_next     = miss_delta;
                            pdelta_next = miss_delta;
                            pend_next   = 1'b1;
                        end
                    end
                    CMD_INSERT:
                    begin
                        wr_val_next   = ins_value;
                        li_next       = ins_value;
                        res_vout_next = ins_value;
                        if (ld_reg != val_reg)
                        begin
                            ld_next     = val_reg;
                            pdelta_next = val_reg;
                            pend_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                        wr_val_next   = val_reg & mask_reg;
                        res_vout_next = val_reg & mask_reg;
                    end
                endcase
            end
            ST_SHIFT:
            begin
                if (shift_more)
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_WRITE:
            begin
                pend_next = 1'b0;
            end
            ST_PREDICT, ST_FINISH:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Output register: filled at the end of an item, emptied when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration writes; the mask is the only register.
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign mask_next = (cfg_wr && (paddr[2] == CFG_IDX_MASK)) ? pwdata : mask_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == CFG_IDX_MASK) ? mask_reg : '0;

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            fill_reg      <= '0;
            li_reg        <= '0;
            ld_reg        <= '0;
            mask_reg      <= MASK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            fill_reg      <= fill_next;
            li_reg        <= li_next;
            ld_reg        <= ld_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        lo_reg       <= lo_next;
        wr_val_reg   <= wr_val_next;
        pdelta_reg   <= pdelta_next;
        res_hit_reg  <= res_hit_next;
        res_idx_reg  <= res_idx_next;
        res_vout_reg <= res_vout_next;
        res_same_reg <= res_same_next;
        if (load_out)
        begin
            out_hit_reg  <= res_hit_reg;
            out_idx_reg  <= HIDX_W'(res_idx_reg);
            out_vout_reg <= res_vout_reg;
            out_same_reg <= res_same_reg;
            out_size_reg <= pred_rsp.size;
        end
    end

    // Cache memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    // Block-size predictor.
    ivcdp_predictor u_predictor (
        .clk   (clk),
        .rst_n (rst_n),
        .mask  (mask_reg),
        .req   (pred_req),
        .rsp   (pred_rsp)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.hit        = out_hit_reg;
    assign out_ch.hit_index  = out_idx_reg;
    assign out_ch.value_out  = out_vout_reg;
    assign out_ch.same_diff  = out_same_reg;
    assign out_ch.block_size = out_size_reg;

    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CACHE_DEPTH))
        else $error("fill count exceeds cache depth");

    // Every memory write lands inside the filled region.
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (FILL_W'(wr_addr) < fill_reg))
        else $error("memory write beyond fill count");

    // A result appears only after an item has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result presented without a finished item");

    // The predictor only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        pred_rsp.done |-> (state_reg == ST_PREDICT))
        else $error("prediction finished outside the predict phase");

endmodule

// File: rtl/ivcdp_predictor.sv
// Serial block-size predictor that walks the bit transitions of a delta.
module ivcdp_predictor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ivcdp_pkg::DATA_W-1:0]  mask,
    input  ivcdp_pkg::pred_req_t          req,
    output ivcdp_pkg::pred_rsp_t          rsp
);
    import ivcdp_pkg::*;

    logic              busy_reg, busy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              prev_reg, prev_next;
    logic [CHG_W-1:0]  change_reg, change_next;
    logic [DATA_W-1:0] delta_reg, delta_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              step_ok;
    logic              cur_bit;
    logic              done;

    // A bit is visited while it lies inside the word and its mask bit is set.
    assign step_ok = !pos_reg[POS_W-1] && mask[pos_reg[CHG_W-1:0]];
    assign cur_bit = delta_reg[pos_reg[CHG_W-1:0]];
    assign done    = busy_reg && !step_ok;

    // One mask bit per cycle; the size is latched when the walk ends.
    always_comb
    begin
        busy_next   = busy_reg;
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        change_next = change_reg;
        delta_next  = delta_reg;
        size_next   = size_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            pos_next    = POS_W'(1);
            prev_next   = req.delta[0];
            change_next = '0;
            delta_next  = req.delta;
        end
        else if (done)
        begin
            busy_next = 1'b0;
            if (change_reg == '0)
            begin
                size_next = BLOCK_SIZE_MIN;
            end
            else
            begin
                size_next = SIZE_W'(change_reg) + SIZE_W'(1);
            end
        end
        else if (busy_reg)
        begin
            if (cur_bit != prev_reg)
            begin
                change_next = pos_reg[CHG_W-1:0];
                prev_next   = cur_bit;
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // Control state and the prediction itself reset; the walk registers do not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            size_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            size_reg <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        prev_reg   <= prev_next;
        change_reg <= change_next;
        delta_reg  <= delta_next;
    end

    assign rsp.done = done;
    assign rsp.size = size_reg;

endmodule
